@@ rtl/core/bba_pkg.sv @@
// Shared types, constants and helpers of the bitmap block allocator.
// Depends on nothing; used by every module of the block.
`default_nettype none

package bba_pkg;

   // Default sizing of the bitmap and of one find run
   localparam int unsigned BITMAP_BYTES_DEF = 512;
   localparam int unsigned MAX_FIND_DEF     = 64;

   // Field widths fixed by the interface
   localparam int unsigned OP_W    = 2;
   localparam int unsigned IDX_W   = 12;
   localparam int unsigned CNT_W   = 7;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned BPOS_W  = 3;

   // Bytes that a 12-bit block index can name
   localparam int unsigned INDEX_SPAN_BYTES = (1 << IDX_W) / BYTE_W;

   // Operation codes
   localparam logic [OP_W-1:0] OP_MARK_USED = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK_FREE = 2'd1;
   localparam logic [OP_W-1:0] OP_TEST      = 2'd2;
   localparam logic [OP_W-1:0] OP_FIND      = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MARK,
      ST_TEST,
      ST_SCAN_WAIT,
      ST_SCAN_BIT,
      ST_FLUSH
   } state_type;

   // One result beat
   typedef struct packed {
      logic [IDX_W-1:0] found_index;
      logic             bit_value;
      logic             found;
      logic             last;
   } rsp_type;

   // Position of the lowest set bit of a byte (0 when none is set)
   function automatic logic [BPOS_W-1:0] lowest_set(input logic [BYTE_W-1:0] v);
      logic [BPOS_W-1:0] pos;
      pos = '0;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            pos = BPOS_W'(i);
         end
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/bitmap_block_allocator.sv @@
// Bitmap block allocator, one item at a time. Mark reads the byte and writes it back;
// test reads the byte and returns its bit. Find reads each byte and returns one beat
// per free block found, the last marked last, or one not-found beat; stalls hold it.
// Reset: after reset is released the bitmap is cleared one byte a cycle,
// and no item is accepted meanwhile.
// Depends on bba_pkg, bba_mem, bba_ctrl and bba_rsp.
`default_nettype none

module bitmap_block_allocator #(
   parameter int unsigned BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF,
   parameter int unsigned MAX_FIND     = bba_pkg::MAX_FIND_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [bba_pkg::OP_W-1:0]    req_operation,
   input  wire logic [bba_pkg::IDX_W-1:0]   req_block_index,
   input  wire logic [bba_pkg::CNT_W-1:0]   req_want_count,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [bba_pkg::IDX_W-1:0]   rsp_found_index,
   output logic                             rsp_bit_value,
   output logic                             rsp_found,
   output logic                             rsp_last
);

   localparam int unsigned AW = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;

   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic [bba_pkg::BYTE_W-1:0]  mem_wr_data;
   logic                        mem_rd_en;
   logic [AW-1:0]               mem_rd_addr;
   logic [bba_pkg::BYTE_W-1:0]  mem_rd_data;
   logic                        push_valid;
   logic                        push_ready;
   bba_pkg::rsp_type            push_data;

   bba_mem #(
      .DEPTH (BITMAP_BYTES),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bba_ctrl #(
      .BITMAP_BYTES (BITMAP_BYTES),
      .MAX_FIND     (MAX_FIND),
      .AW           (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_block_index (req_block_index),
      .req_want_count  (req_want_count),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   bba_rsp u_rsp (
      .clock           (clock),
      .reset           (reset),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found_index (rsp_found_index),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ rtl/core/bba_mem.sv @@
// Bitmap storage: one write port, one read port with registered read data.
// Depends on bba_pkg for the byte width.
`default_nettype none

module bba_mem #(
   parameter int unsigned DEPTH = bba_pkg::BITMAP_BYTES_DEF,
   parameter int unsigned AW    = 9
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [bba_pkg::BYTE_W-1:0] wr_data,
   input  wire logic                       rd_en,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [bba_pkg::BYTE_W-1:0] rd_data
);

   logic [bba_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [bba_pkg::BYTE_W-1:0] rd_data_ff;

   // Write one byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one byte, hold it until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/bba_rsp.sv @@
// Result output register: parts the sequencer from the result channel.
// Depends on bba_pkg for the result beat type.
`default_nettype none

module bba_rsp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push_valid,
   output logic                                push_ready,
   input  wire bba_pkg::rsp_type               push_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [bba_pkg::IDX_W-1:0]      rsp_found_index,
   output logic                                rsp_bit_value,
   output logic                                rsp_found,
   output logic                                rsp_last
);

   logic             valid_ff;
   logic             valid_in;
   bba_pkg::rsp_type data_ff;

   // Take a new beat when empty or when the held beat leaves
   assign push_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push_ready) begin
         valid_in = push_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ready && push_valid) begin
         data_ff <= push_data;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_found_index = data_ff.found_index;
   assign rsp_bit_value   = data_ff.bit_value;
   assign rsp_found       = data_ff.found;
   assign rsp_last        = data_ff.last;

endmodule

`default_nettype wire

@@ rtl/core/bba_ctrl.sv @@
// Sequencer: clears the bitmap, runs read-modify-write for marks, tests
// bits and scans for free blocks. Depends on bba_pkg; drives bba_mem.
`default_nettype none

module bba_ctrl #(
   parameter int unsigned BITMAP_BYTES = bba_pkg::BITMAP_BYTES_DEF,
   parameter int unsigned MAX_FIND     = bba_pkg::MAX_FIND_DEF,
   parameter int unsigned AW           = 9
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [bba_pkg::OP_W-1:0]    req_operation,
   input  wire logic [bba_pkg::IDX_W-1:0]   req_block_index,
   input  wire logic [bba_pkg::CNT_W-1:0]   req_want_count,
   output logic                             mem_wr_en,
   output logic      [AW-1:0]               mem_wr_addr,
   output logic      [bba_pkg::BYTE_W-1:0]  mem_wr_data,
   output logic                             mem_rd_en,
   output logic      [AW-1:0]               mem_rd_addr,
   input  wire logic [bba_pkg::BYTE_W-1:0]  mem_rd_data,
   output logic                             push_valid,
   input  wire logic                        push_ready,
   output bba_pkg::rsp_type                 push_data
);

   localparam int unsigned SCAN_BYTES =
      (BITMAP_BYTES < bba_pkg::INDEX_SPAN_BYTES) ? BITMAP_BYTES : bba_pkg::INDEX_SPAN_BYTES;
   localparam logic [AW-1:0] LAST_ADDR = AW'(BITMAP_BYTES - 1);
   localparam logic [AW-1:0] LAST_SCAN = AW'(SCAN_BYTES - 1);
   localparam int unsigned   RBYTE_W   = bba_pkg::IDX_W - bba_pkg::BPOS_W;

   bba_pkg::state_type state_ff, state_in;
   logic [AW-1:0]                ptr_ff, ptr_in;
   logic [bba_pkg::BYTE_W-1:0]   free_ff, free_in;
   logic [bba_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [bba_pkg::CNT_W-1:0]    want_ff, want_in;
   logic                         pend_valid_ff, pend_valid_in;
   logic [bba_pkg::IDX_W-1:0]    pend_idx_ff, pend_idx_in;
   logic [bba_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                         set_ff, set_in;
   logic                         in_range_ff, in_range_in;

   logic [RBYTE_W-1:0]           req_byte;
   logic                         req_in_range;
   logic [AW-1:0]                req_addr;
   logic [bba_pkg::CNT_W-1:0]    req_want_sat;
   logic [bba_pkg::BPOS_W-1:0]   lo_pos;
   logic [bba_pkg::IDX_W-1:0]    cand_idx;
   logic [bba_pkg::CNT_W-1:0]    cnt_next;
   logic [bba_pkg::BYTE_W-1:0]   bit_mask;

   // Decode the request and the scan candidate
   always_comb begin
      req_byte     = req_block_index[bba_pkg::IDX_W-1:bba_pkg::BPOS_W];
      req_in_range = 32'(req_byte) < BITMAP_BYTES;
      req_addr     = AW'(req_byte);
      if (req_want_count == '0) begin
         req_want_sat = bba_pkg::CNT_W'(1);
      end else if (32'(req_want_count) > MAX_FIND) begin
         req_want_sat = bba_pkg::CNT_W'(MAX_FIND);
      end else begin
         req_want_sat = req_want_count;
      end
      lo_pos   = bba_pkg::lowest_set(free_ff);
      cand_idx = bba_pkg::IDX_W'({ptr_ff, lo_pos});
      cnt_next = cnt_ff + bba_pkg::CNT_W'(1);
      bit_mask = bba_pkg::BYTE_W'(1) << idx_ff[bba_pkg::BPOS_W-1:0];
   end

   // Next state and next register values
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      free_in       = free_ff;
      cnt_in        = cnt_ff;
      want_in       = want_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      idx_in        = idx_ff;
      set_in        = set_ff;
      in_range_in   = in_range_ff;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = bba_pkg::ST_IDLE;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         bba_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_operation)
                  bba_pkg::OP_MARK_USED, bba_pkg::OP_MARK_FREE: begin
                     ptr_in = req_addr;
                     idx_in = req_block_index;
                     set_in = (req_operation == bba_pkg::OP_MARK_USED);
                     // drop marks beyond the bitmap
                     if (req_in_range) begin
                        state_in = bba_pkg::ST_MARK;
                     end
                  end
                  bba_pkg::OP_TEST: begin
                     idx_in      = req_block_index;
                     in_range_in = req_in_range;
                     state_in    = bba_pkg::ST_TEST;
                  end
                  bba_pkg::OP_FIND: begin
                     ptr_in        = '0;
                     want_in       = req_want_sat;
                     cnt_in        = '0;
                     pend_valid_in = 1'b0;
                     state_in      = bba_pkg::ST_SCAN_WAIT;
                  end
                  default: begin
                     state_in = bba_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         bba_pkg::ST_MARK: begin
            state_in = bba_pkg::ST_IDLE;
         end
         bba_pkg::ST_TEST: begin
            if (push_ready) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         bba_pkg::ST_SCAN_WAIT: begin
            free_in  = ~mem_rd_data;
            state_in = bba_pkg::ST_SCAN_BIT;
         end
         bba_pkg::ST_SCAN_BIT: begin
            if (free_ff != '0) begin
               // hold the newest candidate; the older one leaves as not last
               if (!pend_valid_ff || push_ready) begin
                  pend_valid_in = 1'b1;
                  pend_idx_in   = cand_idx;
                  free_in       = free_ff & ~(bba_pkg::BYTE_W'(1) << lo_pos);
                  cnt_in        = cnt_next;
                  if (cnt_next == want_ff) begin
                     state_in = bba_pkg::ST_FLUSH;
                  end
               end
            end else if (ptr_ff == LAST_SCAN) begin
               state_in = bba_pkg::ST_FLUSH;
            end else begin
               ptr_in   = ptr_ff + AW'(1);
               state_in = bba_pkg::ST_SCAN_WAIT;
            end
         end
         bba_pkg::ST_FLUSH: begin
            if (push_ready) begin
               pend_valid_in = 1'b0;
               state_in      = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   // Memory accesses, request ready and result beats
   always_comb begin
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = ptr_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;
      push_valid  = 1'b0;
      push_data   = '0;
      unique case (state_ff)
         bba_pkg::ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         bba_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            mem_rd_en = req_valid;
            if (req_operation == bba_pkg::OP_FIND) begin
               mem_rd_addr = '0;
            end else begin
               mem_rd_addr = req_addr;
            end
         end
         bba_pkg::ST_MARK: begin
            mem_wr_en = 1'b1;
            if (set_ff) begin
               mem_wr_data = mem_rd_data | bit_mask;
            end else begin
               mem_wr_data = mem_rd_data & ~bit_mask;
            end
         end
         bba_pkg::ST_TEST: begin
            push_valid            = 1'b1;
            push_data.found_index = idx_ff;
            push_data.bit_value   = in_range_ff && ((mem_rd_data & bit_mask) != '0);
            push_data.last        = 1'b1;
         end
         bba_pkg::ST_SCAN_WAIT: begin
            mem_rd_en = 1'b0;
         end
         bba_pkg::ST_SCAN_BIT: begin
            if (free_ff != '0) begin
               push_valid            = pend_valid_ff;
               push_data.found_index = pend_idx_ff;
               push_data.found       = 1'b1;
            end else if (ptr_ff != LAST_SCAN) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff + AW'(1);
            end
         end
         bba_pkg::ST_FLUSH: begin
            // last candidate, or the single not-found beat
            push_valid     = 1'b1;
            push_data.last = 1'b1;
            if (pend_valid_ff) begin
               push_data.found_index = pend_idx_ff;
               push_data.found       = 1'b1;
            end
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bba_pkg::ST_CLEAR;
         ptr_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ptr_ff        <= ptr_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      free_ff     <= free_in;
      cnt_ff      <= cnt_in;
      want_ff     <= want_in;
      pend_idx_ff <= pend_idx_in;
      idx_ff      <= idx_in;
      set_ff      <= set_in;
      in_range_ff <= in_range_in;
   end

endmodule

`default_nettype wire
